### src/atsc_pkg.sv
`default_nettype none

package atsc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NORM_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_H_NORM_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT   = 3'd4;

    localparam logic [63:0] STEP_RESET = 64'd4294967;
    localparam logic [63:0] ALL_ONES   = '1;

    // byte-serial divide by three: 8 bytes per step value
    localparam int unsigned DIV_STEPS = 8;
    // bit-serial remainder over the 64-bit overshoot
    localparam int unsigned MOD_STEPS = 64;

    typedef struct packed {
        logic [31:0] h_norm_update;
        logic [31:0] max_norm_update;
        logic [15:0] solver_iterations;
    } report_t;

    typedef struct packed {
        logic [63:0] current_time;
        logic [63:0] next_step;
        logic        snapshot_now;
    } result_t;

    typedef enum logic [1:0] {
        ADAPT_KEEP,
        ADAPT_SHRINK,
        ADAPT_GROW
    } adapt_t;

    typedef struct packed {
        logic load_report;
        logic add_time;
        logic step_grow;
        logic div_start;
        logic div_step;
        logic div_last;
        logic snap_eval;
        logic mark_sat;
        logic mod_start;
        logic mod_step;
        logic mark_update;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        adapt_t adapt;
        logic   snap;
        logic   interval_zero;
    } dp_status_t;

endpackage

`default_nettype wire

### src/atsc_dp.sv
`default_nettype none

module atsc_dp
    import atsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    input  wire report_t              report,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    output result_t                   result
);

    // configuration and architectural state
    logic [31:0] max_lim_reg, max_lim_next;
    logic [31:0] h_lim_reg, h_lim_next;
    logic [63:0] interval_reg, interval_next;
    logic [15:0] iter_lim_reg, iter_lim_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic [63:0] step_reg, step_next;
    logic [63:0] mark_reg, mark_next;

    // working registers
    report_t     report_reg, report_next;
    logic        snap_reg, snap_next;
    logic [63:0] div_src_reg, div_src_next;
    logic [63:0] div_q_reg, div_q_next;
    logic [1:0]  div_rem_reg, div_rem_next;
    logic [63:0] mod_dvd_reg, mod_dvd_next;
    logic [63:0] mod_rem_reg, mod_rem_next;
    result_t     result_reg, result_next;

    logic [64:0] time_sum;
    logic [65:0] triple;
    logic [63:0] triple_sat;
    logic [9:0]  div_v;
    logic [20:0] div_prod;
    logic [7:0]  div_qb;
    logic [9:0]  div_rb;
    logic [63:0] div_q_new;
    logic [64:0] mod_shift;
    logic [64:0] mod_diff;
    logic [63:0] mark_base;
    logic [64:0] mark_sum;
    logic [35:0] h_x9;
    logic [35:0] m_x9;
    logic        adapt_en;

    // status
    always_comb
    begin
        adapt_en = (max_lim_reg != '0) && (h_lim_reg != '0)
                && (report_reg.h_norm_update != '0) && (report_reg.max_norm_update != '0);
        h_x9 = {1'b0, report_reg.h_norm_update, 3'b000}
             + {4'b0000, report_reg.h_norm_update};
        m_x9 = {1'b0, report_reg.max_norm_update, 3'b000}
             + {4'b0000, report_reg.max_norm_update};
        status.adapt = ADAPT_KEEP;
        if (adapt_en)
        begin
            if ((iter_lim_reg != '0) && (report_reg.solver_iterations >= iter_lim_reg))
                status.adapt = ADAPT_SHRINK;
            else if ((report_reg.h_norm_update > h_lim_reg)
                  || (report_reg.max_norm_update > max_lim_reg))
                status.adapt = ADAPT_SHRINK;
            else if ((h_x9 < {4'b0000, h_lim_reg}) && (m_x9 < {4'b0000, max_lim_reg}))
                status.adapt = ADAPT_GROW;
        end
        status.snap          = elapsed_reg > mark_reg;
        status.interval_zero = interval_reg == '0;
    end

    // arithmetic
    always_comb
    begin
        time_sum   = {1'b0, elapsed_reg} + {1'b0, step_reg};
        triple     = {2'b00, step_reg} + {1'b0, step_reg, 1'b0};
        triple_sat = (triple[65:64] != 2'b00) ? ALL_ONES : triple[63:0];

        // 683/2048 is within 1/6144 of one third: exact floor for values under 1024
        div_v     = {div_rem_reg, div_src_reg[63:56]};
        div_prod  = {11'd0, div_v} * 21'd683;
        div_qb    = div_prod[18:11];
        div_rb    = div_v - {1'b0, div_qb, 1'b0} - {2'b00, div_qb};
        div_q_new = {div_q_reg[55:0], div_qb};

        mod_shift = {mod_rem_reg, mod_dvd_reg[63]};
        mod_diff  = mod_shift - {1'b0, interval_reg};

        // new mark = time - ((time - mark) mod interval) + interval
        mark_base = elapsed_reg - mod_rem_reg;
        mark_sum  = {1'b0, mark_base} + {1'b0, interval_reg};
    end

    always_comb
    begin
        max_lim_next  = max_lim_reg;
        h_lim_next    = h_lim_reg;
        interval_next = interval_reg;
        iter_lim_next = iter_lim_reg;
        elapsed_next  = elapsed_reg;
        step_next     = step_reg;
        mark_next     = mark_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INITIAL_STEP:
                    step_next = (cfg_data == '0) ? 64'd1 : cfg_data;
                CFG_MAX_NORM_LIMIT:
                    max_lim_next = cfg_data[31:0];
                CFG_H_NORM_LIMIT:
                    h_lim_next = cfg_data[31:0];
                CFG_SNAPSHOT_INTERVAL:
                begin
                    interval_next = cfg_data;
                    mark_next     = (cfg_data == '0) ? ALL_ONES : '0;
                end
                CFG_ITERATION_LIMIT:
                    iter_lim_next = cfg_data[15:0];
                default:
                    ;
            endcase
        end

        if (cmd.add_time)
            elapsed_next = time_sum[64] ? ALL_ONES : time_sum[63:0];
        if (cmd.step_grow)
            step_next = triple_sat;
        if (cmd.div_last)
            step_next = (div_q_new == '0) ? 64'd1 : div_q_new;
        if (cmd.mark_sat)
            mark_next = ALL_ONES;
        if (cmd.mark_update)
            mark_next = mark_sum[64] ? ALL_ONES : mark_sum[63:0];
    end

    always_comb
    begin
        report_next  = report_reg;
        snap_next    = snap_reg;
        div_src_next = div_src_reg;
        div_q_next   = div_q_reg;
        div_rem_next = div_rem_reg;
        mod_dvd_next = mod_dvd_reg;
        mod_rem_next = mod_rem_reg;
        result_next  = result_reg;

        if (cmd.load_report)
            report_next = report;
        if (cmd.snap_eval)
            snap_next = status.snap;
        if (cmd.div_start)
        begin
            div_src_next = step_reg;
            div_q_next   = '0;
            div_rem_next = '0;
        end
        if (cmd.div_step)
        begin
            div_src_next = {div_src_reg[55:0], 8'h00};
            div_q_next   = div_q_new;
            div_rem_next = div_rb[1:0];
        end
        if (cmd.mod_start)
        begin
            mod_dvd_next = elapsed_reg - mark_reg;
            mod_rem_next = '0;
        end
        if (cmd.mod_step)
        begin
            mod_dvd_next = {mod_dvd_reg[62:0], 1'b0};
            mod_rem_next = mod_diff[64] ? mod_shift[63:0] : mod_diff[63:0];
        end
        if (cmd.load_result)
        begin
            result_next.current_time = elapsed_reg;
            result_next.next_step    = step_reg;
            result_next.snapshot_now = snap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lim_reg  <= '0;
            h_lim_reg    <= '0;
            interval_reg <= '0;
            iter_lim_reg <= '0;
            elapsed_reg  <= '0;
            step_reg     <= STEP_RESET;
            mark_reg     <= ALL_ONES;
        end
        else
        begin
            max_lim_reg  <= max_lim_next;
            h_lim_reg    <= h_lim_next;
            interval_reg <= interval_next;
            iter_lim_reg <= iter_lim_next;
            elapsed_reg  <= elapsed_next;
            step_reg     <= step_next;
            mark_reg     <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        report_reg  <= report_next;
        snap_reg    <= snap_next;
        div_src_reg <= div_src_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        mod_dvd_reg <= mod_dvd_next;
        mod_rem_reg <= mod_rem_next;
        result_reg  <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### src/atsc_ctrl.sv
`default_nettype none

module atsc_ctrl
    import atsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       report_valid,
    output logic            report_stall,
    output logic            result_valid,
    input  wire logic       result_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_ADAPT,
        ST_DIV,
        ST_SNAP,
        ST_MOD,
        ST_MARK,
        ST_DONE
    } state_t;

    localparam int unsigned CNT_W = $clog2(MOD_STEPS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             result_valid_reg, result_valid_next;
    logic             out_free;

    assign out_free     = !result_valid_reg || !result_stall;
    assign report_stall = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd               = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (report_valid)
                begin
                    cmd.load_report = 1'b1;
                    state_next      = ST_TIME;
                end
            end
            ST_TIME:
            begin
                cmd.add_time = 1'b1;
                state_next   = ST_ADAPT;
            end
            ST_ADAPT:
            begin
                cnt_next = '0;
                unique case (status.adapt)
                    ADAPT_SHRINK:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    ADAPT_GROW:
                    begin
                        cmd.step_grow = 1'b1;
                        state_next    = ST_SNAP;
                    end
                    default:
                        state_next = ST_SNAP;
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_SNAP;
                end
            end
            ST_SNAP:
            begin
                cmd.snap_eval = 1'b1;
                cnt_next      = '0;
                if (status.snap && status.interval_zero)
                begin
                    cmd.mark_sat = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (status.snap)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MOD_STEPS - 1))
                    state_next = ST_MARK;
            end
            ST_MARK:
            begin
                cmd.mark_update = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_result   = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

`default_nettype wire

### src/adaptive_time_step_controller.sv
`default_nettype none

// Adaptive time-step controller. Each report of a finished solver step adds the
// current step to the Q32.32 elapsed time (saturating), shrinks the step by three
// or grows it by three from the norms and iteration count, and flags a snapshot
// when the time passes the due mark. After a report transfer the input stays
// stalled until the result is loaded: time add, adapt, a byte-serial divide by
// three on a shrink, snapshot check, and for a due snapshot with a nonzero
// interval a bit-serial remainder of the overshoot by the interval, then the
// mark update; a stalled result adds its stall time only once a second result
// is ready. Configuration writes are taken every cycle (cfg_ready is tied high);
// the user must keep them to idle time, the block does not enforce it; writing
// initial_step reloads the step, writing snapshot_interval rearms the mark.

module adaptive_time_step_controller
    import atsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 report_valid,
    output logic                      report_stall,
    input  wire report_t              report,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    atsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    atsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .report    (report),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

`default_nettype wire

### src/atsc_checker.sv
`default_nettype none

module atsc_checker
    import atsc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    report_valid,
    input wire logic    report_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result,
    input wire logic    cfg_valid,
    input wire logic    cfg_ready
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // one report at a time: busy right after a transfer
    a_busy_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_stall |=> report_stall)
        else $error("second report taken without a gap");

    // the step floor holds on every result
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.next_step != '0)
        else $error("zero step reported");

    // a snapshot needs time past a mark of at least zero
    a_snap_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.snapshot_now |-> result.current_time != '0)
        else $error("snapshot at time zero");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind adaptive_time_step_controller atsc_checker u_atsc_checker (.*);

`default_nettype wire
